[design/assert_macros.svh]
// Assertion macros shared by the accuracy counter RTL.
// Included by files that carry concurrent checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// property that must hold at every clock edge outside reset
`define ASSERT_ALWAYS(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
// implication whose consequent is checked in the following cycle
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_ALWAYS(lbl, clk, rstn, prop, msg)
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

[design/t1acc_pkg.sv]
// Shared types and constants for the top-1 accuracy counter.
// No dependencies; used by every module of the block.
package t1acc_pkg;

  // defaults for the top-level parameters
  localparam int unsigned MAX_CLASSES_DEF = 256;
  localparam int unsigned MAX_ROWS_DEF    = 1048576;
  localparam int unsigned SCORE_WIDTH_DEF = 32;

  // fixed field widths
  localparam int unsigned IN_SCORE_W = 32;
  localparam int unsigned LABEL_W    = 8;
  localparam int unsigned CFG_W      = 9;
  localparam int unsigned CNT_OUT_W  = 21;
  localparam int unsigned ACC_W      = 23;
  localparam int unsigned IN_DATA_W  = 40;
  localparam int unsigned OUT_DATA_W = 72;

  // num_classes after reset
  localparam logic [CFG_W-1:0] NUM_CLASSES_RST = 9'd10;

  // row event queue depth
  localparam int unsigned EVT_DEPTH = 4;

  // one closed row, passed from front to back
  typedef struct packed {
    logic correct;
    logic last;
  } row_evt_t;

  // queue status seen by both sides
  typedef struct packed {
    logic full;
    logic empty;
  } evt_q_stat_t;

  // back end sequencer
  typedef enum logic [1:0] {
    B_RUN,
    B_LOAD,
    B_DIV,
    B_OUT
  } back_state_t;

endpackage

[design/t1acc_front.sv]
// Front end: holds num_classes, tracks the running argmax per row and
// emits one row event per closed row. Depends on t1acc_pkg.
module t1acc_front #(
  parameter int unsigned MAX_CLASSES = t1acc_pkg::MAX_CLASSES_DEF,
  parameter int unsigned SCORE_WIDTH = t1acc_pkg::SCORE_WIDTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_wr_en,
  input  logic [t1acc_pkg::CFG_W-1:0]        cfg_wr_data,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [t1acc_pkg::IN_SCORE_W-1:0]   in_score,
  input  logic [t1acc_pkg::LABEL_W-1:0]      in_label,
  input  logic                               in_last,
  input  t1acc_pkg::evt_q_stat_t             q_stat,
  output logic                               evt_push,
  output t1acc_pkg::row_evt_t                evt_data
);

  localparam int unsigned IDX_W = (MAX_CLASSES > 2) ? $clog2(MAX_CLASSES) : 1;
  localparam int unsigned COL_W = $clog2(MAX_CLASSES + 1);
  localparam int unsigned NC_W  = (COL_W > t1acc_pkg::CFG_W) ? COL_W : t1acc_pkg::CFG_W;
  localparam int unsigned CMP_W = (IDX_W > t1acc_pkg::LABEL_W) ? IDX_W : t1acc_pkg::LABEL_W;

  logic [t1acc_pkg::CFG_W-1:0] num_classes_r;
  logic [IDX_W-1:0]            col_r, col_nxt;
  logic [IDX_W-1:0]            best_idx_r, best_idx_nxt;
  logic signed [SCORE_WIDTH-1:0] best_r, best_nxt;
  logic signed [SCORE_WIDTH-1:0] score_s;
  logic [NC_W-1:0]             ncls_eff, cfg_ext, col_inc;
  logic                        accept, row_close;

  // config register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_classes_r <= t1acc_pkg::NUM_CLASSES_RST;
    end else if (cfg_wr_en) begin
      num_classes_r <= cfg_wr_data;
    end
  end

  // clamp class count to 1..MAX_CLASSES
  always_comb begin
    cfg_ext = NC_W'(num_classes_r);
    if (cfg_ext == '0) begin
      ncls_eff = NC_W'(1);
    end else if (cfg_ext > NC_W'(MAX_CLASSES)) begin
      ncls_eff = NC_W'(MAX_CLASSES);
    end else begin
      ncls_eff = cfg_ext;
    end
  end

  assign in_ready = !q_stat.full;
  assign accept   = in_valid && in_ready;
  assign score_s  = signed'(in_score[SCORE_WIDTH-1:0]);
  assign col_inc  = NC_W'(col_r) + NC_W'(1);

  // running argmax; strict compare keeps the first index on ties
  always_comb begin
    best_nxt     = best_r;
    best_idx_nxt = best_idx_r;
    if (col_r == '0) begin
      best_nxt     = score_s;
      best_idx_nxt = '0;
    end else if (score_s > best_r) begin
      best_nxt     = score_s;
      best_idx_nxt = col_r;
    end
    row_close        = (col_inc >= ncls_eff) || in_last;
    col_nxt          = row_close ? '0 : IDX_W'(col_inc);
    evt_data.correct = (CMP_W'(best_idx_nxt) == CMP_W'(in_label));
    evt_data.last    = in_last;
    evt_push         = accept && row_close;
  end

  // column position
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
    end else if (accept) begin
      col_r <= col_nxt;
    end
  end

  // best score and index
  always_ff @(posedge clk) begin
    if (accept) begin
      best_r     <= best_nxt;
      best_idx_r <= best_idx_nxt;
    end
  end

endmodule

[design/t1acc_evt_fifo.sv]
// Short queue of row events between front and back end.
// Depends on t1acc_pkg for the event and status types.
module t1acc_evt_fifo #(
  parameter int unsigned DEPTH = t1acc_pkg::EVT_DEPTH
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   push,
  input  t1acc_pkg::row_evt_t    push_data,
  input  logic                   pop,
  output t1acc_pkg::row_evt_t    pop_data,
  output t1acc_pkg::evt_q_stat_t stat
);

  localparam int unsigned PTR_W = (DEPTH > 2) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  t1acc_pkg::row_evt_t entry_r [DEPTH];
  logic [PTR_W-1:0]    wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0]    count_r;
  logic                do_push, do_pop;

  assign stat.full  = (count_r == CNT_W'(DEPTH));
  assign stat.empty = (count_r == '0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign pop_data   = entry_r[rd_ptr_r];

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      case ({do_push, do_pop})
        2'b10:   count_r <= count_r + CNT_W'(1);
        2'b01:   count_r <= count_r - CNT_W'(1);
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

[design/t1acc_back.sv]
// Back end: saturating row and hit counters, bit-serial accuracy divider
// and the result register. Depends on t1acc_pkg.
module t1acc_back #(
  parameter int unsigned MAX_ROWS = t1acc_pkg::MAX_ROWS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  t1acc_pkg::evt_q_stat_t              q_stat,
  input  t1acc_pkg::row_evt_t                 evt_data,
  output logic                                evt_pop,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [t1acc_pkg::CNT_OUT_W-1:0]     out_correct,
  output logic [t1acc_pkg::CNT_OUT_W-1:0]     out_rows,
  output logic [t1acc_pkg::ACC_W-1:0]         out_acc
);

  localparam int unsigned CNT_W  = $clog2(MAX_ROWS + 1);
  localparam int unsigned QW     = t1acc_pkg::ACC_W;
  localparam int unsigned NUM_W  = CNT_W + QW;
  localparam int unsigned STEP_W = $clog2(QW);

  t1acc_pkg::back_state_t state_r, state_nxt;

  logic [CNT_W-1:0]  rows_r, rows_nxt, hits_r, hits_nxt;
  logic [CNT_W-1:0]  res_rows_r, res_hits_r;
  logic [CNT_W-1:0]  rem_r, rem_nxt;
  logic [QW-1:0]     quo_r, quo_nxt;
  logic [QW-1:0]     acc_r, acc_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [NUM_W-1:0]  numer;
  logic [CNT_W:0]    trial;
  logic              res_load;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
    return (c >= CNT_W'(MAX_ROWS)) ? CNT_W'(MAX_ROWS) : c + CNT_W'(1);
  endfunction

  // hits * 100 * 65536 as shifted adds (100 = 64 + 32 + 4)
  assign numer = (NUM_W'(res_hits_r) << 22) + (NUM_W'(res_hits_r) << 21)
               + (NUM_W'(res_hits_r) << 18);

  // one restoring step: quotient fits QW bits since hits <= rows
  assign trial = {rem_r, quo_r[QW-1]};

  // sequencer
  always_comb begin
    state_nxt = state_r;
    rows_nxt  = rows_r;
    hits_nxt  = hits_r;
    rem_nxt   = rem_r;
    quo_nxt   = quo_r;
    acc_nxt   = acc_r;
    step_nxt  = step_r;
    evt_pop   = 1'b0;
    res_load  = 1'b0;
    unique case (state_r)
      t1acc_pkg::B_RUN: begin
        if (!q_stat.empty) begin
          evt_pop  = 1'b1;
          rows_nxt = sat_inc(rows_r);
          hits_nxt = evt_data.correct ? sat_inc(hits_r) : hits_r;
          if (evt_data.last) begin
            res_load  = 1'b1;
            rows_nxt  = '0;
            hits_nxt  = '0;
            state_nxt = t1acc_pkg::B_LOAD;
          end
        end
      end
      t1acc_pkg::B_LOAD: begin
        rem_nxt   = numer[NUM_W-1:QW];
        quo_nxt   = numer[QW-1:0];
        step_nxt  = '0;
        state_nxt = t1acc_pkg::B_DIV;
      end
      t1acc_pkg::B_DIV: begin
        if (trial >= {1'b0, res_rows_r}) begin
          rem_nxt = CNT_W'(trial - {1'b0, res_rows_r});
          quo_nxt = {quo_r[QW-2:0], 1'b1};
        end else begin
          rem_nxt = trial[CNT_W-1:0];
          quo_nxt = {quo_r[QW-2:0], 1'b0};
        end
        step_nxt = step_r + STEP_W'(1);
        if (step_r == STEP_W'(QW - 1)) begin
          acc_nxt   = (res_rows_r == '0) ? '0 : quo_nxt;
          state_nxt = t1acc_pkg::B_OUT;
        end
      end
      t1acc_pkg::B_OUT: begin
        if (out_ready) begin
          state_nxt = t1acc_pkg::B_RUN;
        end
      end
      default: state_nxt = t1acc_pkg::B_RUN;
    endcase
  end

  // control state and counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= t1acc_pkg::B_RUN;
      rows_r  <= '0;
      hits_r  <= '0;
    end else begin
      state_r <= state_nxt;
      rows_r  <= rows_nxt;
      hits_r  <= hits_nxt;
    end
  end

  // divider datapath and result
  always_ff @(posedge clk) begin
    rem_r  <= rem_nxt;
    quo_r  <= quo_nxt;
    acc_r  <= acc_nxt;
    step_r <= step_nxt;
    if (res_load) begin
      res_rows_r <= sat_inc(rows_r);
      res_hits_r <= evt_data.correct ? sat_inc(hits_r) : hits_r;
    end
  end

  assign out_valid   = (state_r == t1acc_pkg::B_OUT);
  assign out_correct = t1acc_pkg::CNT_OUT_W'(res_hits_r);
  assign out_rows    = t1acc_pkg::CNT_OUT_W'(res_rows_r);
  assign out_acc     = acc_r;

endmodule

[design/top1_accuracy_counter_unit.sv]
// Top level of the streaming top-1 accuracy counter.
// Depends on t1acc_pkg, t1acc_front, t1acc_evt_fifo, t1acc_back, assert_macros.svh.
//
// Scores stream in one per clock, num_classes per row, each with its row's
// label; in_tlast marks the final score of the set and also closes a
// partial row. The front end takes one score every cycle while the
// four-entry row event queue has room. The back end retires one row event
// per cycle while in its run state; on the set's last event it runs a
// restoring divider, one quotient bit per cycle: a load step, then the
// divider steps, the last of which writes the result register. The result
// holds until out_tready. Meanwhile the front keeps accepting scores until
// the row event queue is full. Row and hit counters saturate at MAX_ROWS.
`include "assert_macros.svh"

module top1_accuracy_counter_unit #(
  parameter int unsigned MAX_CLASSES = t1acc_pkg::MAX_CLASSES_DEF,
  parameter int unsigned MAX_ROWS    = t1acc_pkg::MAX_ROWS_DEF,
  parameter int unsigned SCORE_WIDTH = t1acc_pkg::SCORE_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_wr_en,
  input  logic [t1acc_pkg::CFG_W-1:0]         cfg_wr_data,   // num_classes
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [t1acc_pkg::IN_DATA_W-1:0]     in_tdata,      // score[31:0], label[39:32]
  input  logic                                in_tlast,      // last_in_set
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // correct_count[20:0], row_count[41:21], accuracy_percent[64:42], zeros[71:65]
  output logic [t1acc_pkg::OUT_DATA_W-1:0]    out_tdata
);

  t1acc_pkg::evt_q_stat_t q_stat;
  t1acc_pkg::row_evt_t    push_evt, pop_evt;
  logic                   evt_push, evt_pop;
  logic [t1acc_pkg::CNT_OUT_W-1:0] res_correct, res_rows;
  logic [t1acc_pkg::ACC_W-1:0]     res_acc;

  // argmax front end
  t1acc_front #(
    .MAX_CLASSES (MAX_CLASSES),
    .SCORE_WIDTH (SCORE_WIDTH)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_tvalid),
    .in_ready    (in_tready),
    .in_score    (in_tdata[31:0]),
    .in_label    (in_tdata[39:32]),
    .in_last     (in_tlast),
    .q_stat      (q_stat),
    .evt_push    (evt_push),
    .evt_data    (push_evt)
  );

  // row event queue
  t1acc_evt_fifo #(
    .DEPTH (t1acc_pkg::EVT_DEPTH)
  ) u_evt_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (evt_push),
    .push_data (push_evt),
    .pop       (evt_pop),
    .pop_data  (pop_evt),
    .stat      (q_stat)
  );

  // counters and divider
  t1acc_back #(
    .MAX_ROWS (MAX_ROWS)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_stat      (q_stat),
    .evt_data    (pop_evt),
    .evt_pop     (evt_pop),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .out_correct (res_correct),
    .out_rows    (res_rows),
    .out_acc     (res_acc)
  );

  // result packing
  assign out_tdata = {7'd0, res_acc, res_rows, res_correct};

  // checks
  `ASSERT_ALWAYS(a_hits_le_rows, clk, rst_n, !out_tvalid || (res_correct <= res_rows), "hit count exceeds row count")
  `ASSERT_ALWAYS(a_acc_range, clk, rst_n, !out_tvalid || (res_acc <= 23'd6553600), "accuracy above 100 percent")
  `ASSERT_NEXT(a_last_queued, clk, rst_n, in_tvalid && in_tready && in_tlast, !q_stat.empty, "closing row event lost")

endmodule
